/* sv/jsu_pkg.sv */
// Shared types and constants for the JSON string unescape unit.
// Result kinds, error codes, character codes and the result record.
// No dependencies.
package jsu_pkg;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_CONTROL = 3'd1,
    ERR_ESCAPE  = 3'd2,
    ERR_HEX     = 3'd3,
    ERR_EOD     = 3'd4
  } err_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    err_e       err;
  } rslt_t;

  localparam int unsigned MaxResults = 3;

  localparam logic [7:0] CtrlMax      = 8'h1F;
  localparam logic [7:0] ChBackslash  = 8'h5C;
  localparam logic [7:0] ChSlash      = 8'h2F;
  localparam logic [7:0] ChQuote      = 8'h22;
  localparam logic [7:0] ChB          = 8'h62;
  localparam logic [7:0] ChF          = 8'h66;
  localparam logic [7:0] ChN          = 8'h6E;
  localparam logic [7:0] ChR          = 8'h72;
  localparam logic [7:0] ChT          = 8'h74;
  localparam logic [7:0] ChU          = 8'h75;
  localparam logic [7:0] Backspace    = 8'h08;
  localparam logic [7:0] FormFeed     = 8'h0C;
  localparam logic [7:0] LineFeed     = 8'h0A;
  localparam logic [7:0] CarriageRet  = 8'h0D;
  localparam logic [7:0] Tab          = 8'h09;

  localparam logic [7:0] Utf8Lead2    = 8'hC0;
  localparam logic [7:0] Utf8Lead3    = 8'hE0;
  localparam logic [7:0] Utf8Cont     = 8'h80;

endpackage

/* sv/jsu_if.sv */
// Valid/ready channel interfaces of the JSON string unescape unit.
// Depends on nothing; payload widths are fixed by the byte stream.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_data;

  modport source (output valid, in_byte, end_of_data, input ready);
  modport sink   (input valid, in_byte, end_of_data, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, out_byte, kind, error_code, last, input ready);
  modport sink   (input valid, out_byte, kind, error_code, last, output ready);
endinterface

/* sv/json_string_unescape_unit.sv */
// JSON string body unescaper: input register, decode logic, result buffer.
// Depends on jsu_pkg and the channel interfaces in jsu_if.sv.
//
// Usage: feed the bytes of a string body, starting after the opening
// quote, one byte per transfer on in_i. Set end_of_data to flag the end of
// the data instead of a byte. Each input byte yields zero to three results
// on out_o: decoded bytes, an end marker at the closing quote, or an error.
// The last flag marks the final result caused by one input byte.
//
// A result passes through the input register, then the result buffer,
// before it leaves on out_o. Throughput is one byte per cycle while the
// receiver takes results; a \uXXXX escape that encodes to two or three
// UTF-8 bytes holds the input register while the result buffer drains,
// one result per cycle.
//
// The input register keeps taking one byte while the result buffer waits
// on a stalled receiver; after that in_i.ready drops until results go out.
// Reset empties both stages and puts the decoder in normal text mode.
module json_string_unescape_unit (
  input logic clk_i,
  input logic rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESCAPE = 3'd1,
    MODE_HEX1   = 3'd2,
    MODE_HEX2   = 3'd3,
    MODE_HEX3   = 3'd4,
    MODE_HEX4   = 3'd5
  } mode_e;

  function automatic rslt_t mk_res(logic [7:0] data, kind_e kind, err_e err);
    rslt_t r;
    r.data = data;
    r.kind = kind;
    r.err  = err;
    return r;
  endfunction

  // input register
  logic       a_valid_q;
  logic [7:0] a_byte_q;
  logic       a_eod_q;

  // decoder state
  mode_e       mode_q, mode_d;
  logic [11:0] acc_q, acc_d;

  // result buffer, entry 0 is presented
  rslt_t      buf_q [MaxResults];
  logic [1:0] cnt_q;

  rslt_t      res [MaxResults];
  logic [1:0] nres;
  logic       hex_ok;
  logic [3:0] hex_val;
  logic [15:0] cp;
  logic       buf_free, a_moves, pop;

  assign pop      = (cnt_q != 2'd0) && out_o.ready;
  assign buf_free = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);
  assign a_moves  = a_valid_q && ((nres == 2'd0) || buf_free);
  assign in_i.ready = !a_valid_q || a_moves;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = a_byte_q[3:0];
    if (a_byte_q >= 8'h30 && a_byte_q <= 8'h39) begin
      hex_val = a_byte_q[3:0];
    end else if ((a_byte_q >= 8'h61 && a_byte_q <= 8'h66) ||
                 (a_byte_q >= 8'h41 && a_byte_q <= 8'h46)) begin
      hex_val = a_byte_q[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp = {acc_q, hex_val};

  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    nres   = 2'd0;
    for (int i = 0; i < MaxResults; i++) begin
      res[i] = mk_res(8'h00, KIND_BYTE, ERR_NONE);
    end
    if (a_eod_q) begin
      mode_d = MODE_NORMAL;
      acc_d  = '0;
      nres   = 2'd1;
      res[0] = mk_res(8'h00, KIND_ERROR, ERR_EOD);
    end else begin
      case (mode_q)
        MODE_ESCAPE: begin
          mode_d = MODE_NORMAL;
          nres   = 2'd1;
          case (a_byte_q)
            ChBackslash: res[0] = mk_res(ChBackslash, KIND_BYTE, ERR_NONE);
            ChSlash:     res[0] = mk_res(ChSlash, KIND_BYTE, ERR_NONE);
            ChQuote:     res[0] = mk_res(ChQuote, KIND_BYTE, ERR_NONE);
            ChB:         res[0] = mk_res(Backspace, KIND_BYTE, ERR_NONE);
            ChF:         res[0] = mk_res(FormFeed, KIND_BYTE, ERR_NONE);
            ChN:         res[0] = mk_res(LineFeed, KIND_BYTE, ERR_NONE);
            ChR:         res[0] = mk_res(CarriageRet, KIND_BYTE, ERR_NONE);
            ChT:         res[0] = mk_res(Tab, KIND_BYTE, ERR_NONE);
            ChU: begin
              mode_d = MODE_HEX1;
              acc_d  = '0;
              nres   = 2'd0;
            end
            default: begin
              acc_d  = '0;
              res[0] = mk_res(8'h00, KIND_ERROR, ERR_ESCAPE);
            end
          endcase
        end
        MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
          if (!hex_ok) begin
            mode_d = MODE_NORMAL;
            acc_d  = '0;
            nres   = 2'd1;
            res[0] = mk_res(8'h00, KIND_ERROR, ERR_HEX);
          end else if (mode_q != MODE_HEX4) begin
            acc_d = {acc_q[7:0], hex_val};
            case (mode_q)
              MODE_HEX1: mode_d = MODE_HEX2;
              MODE_HEX2: mode_d = MODE_HEX3;
              default:   mode_d = MODE_HEX4;
            endcase
          end else begin
            mode_d = MODE_NORMAL;
            acc_d  = '0;
            // encode the code point as UTF-8
            if (cp <= 16'h007F) begin
              nres   = 2'd1;
              res[0] = mk_res(cp[7:0], KIND_BYTE, ERR_NONE);
            end else if (cp <= 16'h07FF) begin
              nres   = 2'd2;
              res[0] = mk_res(Utf8Lead2 | {3'b000, cp[10:6]}, KIND_BYTE, ERR_NONE);
              res[1] = mk_res(Utf8Cont | {2'b00, cp[5:0]}, KIND_BYTE, ERR_NONE);
            end else begin
              nres   = 2'd3;
              res[0] = mk_res(Utf8Lead3 | {4'b0000, cp[15:12]}, KIND_BYTE, ERR_NONE);
              res[1] = mk_res(Utf8Cont | {2'b00, cp[11:6]}, KIND_BYTE, ERR_NONE);
              res[2] = mk_res(Utf8Cont | {2'b00, cp[5:0]}, KIND_BYTE, ERR_NONE);
            end
          end
        end
        default: begin
          mode_d = MODE_NORMAL;
          nres   = 2'd1;
          if (a_byte_q <= CtrlMax) begin
            acc_d  = '0;
            res[0] = mk_res(8'h00, KIND_ERROR, ERR_CONTROL);
          end else if (a_byte_q == ChBackslash) begin
            mode_d = MODE_ESCAPE;
            nres   = 2'd0;
          end else if (a_byte_q == ChQuote) begin
            acc_d  = '0;
            res[0] = mk_res(8'h00, KIND_END, ERR_NONE);
          end else begin
            res[0] = mk_res(a_byte_q, KIND_BYTE, ERR_NONE);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      mode_q    <= MODE_NORMAL;
      acc_q     <= '0;
      cnt_q     <= 2'd0;
    end else begin
      if (in_i.ready) begin
        a_valid_q <= in_i.valid;
      end
      if (a_moves) begin
        mode_q <= mode_d;
        acc_q  <= acc_d;
      end
      if (a_moves && (nres != 2'd0)) begin
        cnt_q <= nres;
      end else if (pop) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      a_byte_q <= in_i.in_byte;
      a_eod_q  <= in_i.end_of_data;
    end
    if (a_moves && (nres != 2'd0)) begin
      buf_q <= res;
    end else if (pop) begin
      // advance the buffer by one entry
      for (int i = 0; i < MaxResults - 1; i++) begin
        buf_q[i] <= buf_q[i+1];
      end
    end
  end

  assign out_o.valid      = (cnt_q != 2'd0);
  assign out_o.out_byte   = buf_q[0].data;
  assign out_o.kind       = buf_q[0].kind;
  assign out_o.error_code = buf_q[0].err;
  assign out_o.last       = (cnt_q == 2'd1);

endmodule

/* sv/jsu_checker.sv */
// Port-level checks for the JSON string unescape unit, bound to json_string_unescape_unit.
// Depends on jsu_pkg for result kinds and error codes.
module jsu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic [1:0] kind_i,
  input logic [2:0] error_code_i,
  input logic       last_i
);
  import jsu_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
      $stable(kind_i) && $stable(last_i))
    else $error("stalled result changed");

  a_end_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i != KIND_BYTE) |-> last_i)
    else $error("end or error result not last");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((kind_i == KIND_ERROR) == (error_code_i != ERR_NONE)))
    else $error("error code disagrees with kind");

  a_nonbyte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i != KIND_BYTE) |-> (out_byte_i == 8'h00))
    else $error("non-byte result carries data");

  // a multi-byte sequence continues with a continuation byte
  a_utf8_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i |=>
      out_valid_i && (kind_i == KIND_BYTE) && (out_byte_i[7:6] == 2'b10))
    else $error("continuation byte expected");

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_byte_i   (out_o.out_byte),
  .kind_i       (out_o.kind),
  .error_code_i (out_o.error_code),
  .last_i       (out_o.last)
);

/* dv/tb_top.sv */
// Testbench for json_string_unescape_unit: byte-stream driver, result monitor, scoreboard.
// Depends on jsu_pkg (result kinds, error codes, character codes) and the jsu_if channels.
`timescale 1ns / 100ps

module tb_top;
  import jsu_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 20;

  // Decoder scan position, one step per raw byte.
  typedef enum logic [2:0] {
    ST_TEXT = 3'd0,
    ST_ESC  = 3'd1,
    ST_HEX1 = 3'd2,
    ST_HEX2 = 3'd3,
    ST_HEX3 = 3'd4,
    ST_HEX4 = 3'd5
  } scan_e;

  typedef struct {
    logic [7:0] ch;
    logic       eod;
  } raw_t;

  typedef struct {
    logic [7:0] data;
    kind_e      kind;
    err_e       err;
    logic       last;
  } decoded_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #6 clk_i = ~clk_i;

  raw_t        feed_q[$];
  decoded_t    decoded_q[$];
  scan_e       esc_state = ST_TEXT;
  logic [15:0] code_acc = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_seq = 0;
  int unsigned hold_len = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned esc_rr = 0;

  int unsigned bytes_taken = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;

  raw_t drv_item;
  logic drv_busy;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
    return 5'h10;
  endfunction

  task automatic emit(input logic [7:0] d, input kind_e k, input err_e e, input logic l);
    decoded_q.push_back('{data: d, kind: k, err: e, last: l});
  endtask

  task automatic reject(input err_e e);
    esc_state = ST_TEXT;
    code_acc  = '0;
    emit(8'h00, KIND_ERROR, e, 1'b1);
  endtask

  task automatic encode_utf8(input logic [15:0] cp);
    if (cp <= 16'h007F) begin
      emit(cp[7:0], KIND_BYTE, ERR_NONE, 1'b1);
    end else if (cp <= 16'h07FF) begin
      emit(Utf8Lead2 | {3'b000, cp[10:6]}, KIND_BYTE, ERR_NONE, 1'b0);
      emit(Utf8Cont | {2'b00, cp[5:0]}, KIND_BYTE, ERR_NONE, 1'b1);
    end else begin
      emit(Utf8Lead3 | {4'h0, cp[15:12]}, KIND_BYTE, ERR_NONE, 1'b0);
      emit(Utf8Cont | {2'b00, cp[11:6]}, KIND_BYTE, ERR_NONE, 1'b0);
      emit(Utf8Cont | {2'b00, cp[5:0]}, KIND_BYTE, ERR_NONE, 1'b1);
    end
  endtask

  task automatic unescape_step(input logic [7:0] c, input logic eod);
    logic [4:0]  nib;
    logic [15:0] cp;
    if (eod) begin
      reject(ERR_EOD);
      return;
    end
    case (esc_state)
      ST_ESC: begin
        esc_state = ST_TEXT;
        case (c)
          ChBackslash: emit(ChBackslash, KIND_BYTE, ERR_NONE, 1'b1);
          ChSlash:     emit(ChSlash, KIND_BYTE, ERR_NONE, 1'b1);
          ChQuote:     emit(ChQuote, KIND_BYTE, ERR_NONE, 1'b1);
          ChB:         emit(Backspace, KIND_BYTE, ERR_NONE, 1'b1);
          ChF:         emit(FormFeed, KIND_BYTE, ERR_NONE, 1'b1);
          ChN:         emit(LineFeed, KIND_BYTE, ERR_NONE, 1'b1);
          ChR:         emit(CarriageRet, KIND_BYTE, ERR_NONE, 1'b1);
          ChT:         emit(Tab, KIND_BYTE, ERR_NONE, 1'b1);
          ChU: begin
            esc_state = ST_HEX1;
            code_acc  = '0;
          end
          default:     reject(ERR_ESCAPE);
        endcase
      end
      ST_HEX1, ST_HEX2, ST_HEX3, ST_HEX4: begin
        nib = hex_nibble(c);
        if (nib[4]) begin
          reject(ERR_HEX);
        end else begin
          code_acc = {code_acc[11:0], nib[3:0]};
          if (esc_state != ST_HEX4) begin
            esc_state = scan_e'(esc_state + 3'd1);
          end else begin
            cp        = code_acc;
            code_acc  = '0;
            esc_state = ST_TEXT;
            encode_utf8(cp);
          end
        end
      end
      default: begin
        // unused encodings fall back to plain text
        esc_state = ST_TEXT;
        if (c <= CtrlMax) begin
          reject(ERR_CONTROL);
        end else if (c == ChBackslash) begin
          esc_state = ST_ESC;
        end else if (c == ChQuote) begin
          code_acc = '0;
          emit(8'h00, KIND_END, ERR_NONE, 1'b1);
        end else begin
          emit(c, KIND_BYTE, ERR_NONE, 1'b1);
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic put_byte(input logic [7:0] c);
    feed_q.push_back('{ch: c, eod: 1'b0});
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
    if (v < 4'd10) return "0" + 8'(v);
    return (upper ? "A" : "a") + 8'(v - 4'd10);
  endfunction

  function automatic logic [7:0] escape_char(input int unsigned idx);
    case (idx % 8)
      0: return ChBackslash;
      1: return ChSlash;
      2: return ChQuote;
      3: return ChB;
      4: return ChF;
      5: return ChN;
      6: return ChR;
      default: return ChT;
    endcase
  endfunction

  function automatic logic [15:0] pick_code_point();
    case ($urandom_range(3))
      0: return 16'($urandom_range(16'h007F));
      1: return 16'($urandom_range(16'h07FF, 16'h0080));
      2: return 16'($urandom_range(16'hFFFF, 16'h0800));
      default: begin
        // range boundaries and the surrogate block
        case ($urandom_range(7))
          0: return 16'h0000;
          1: return 16'h007F;
          2: return 16'h0080;
          3: return 16'h07FF;
          4: return 16'h0800;
          5: return 16'hD800;
          6: return 16'hDFFF;
          default: return 16'hFFFF;
        endcase
      end
    endcase
  endfunction

  task automatic queue_directed();
    put_byte(8'h20);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(ChQuote);
    put_byte(ChBackslash);
    put_byte(CtrlMax);
    // \u0000 gives a single zero byte
    put_byte(ChBackslash);
    put_byte(ChU);
    repeat (4) put_byte("0");
    // mixed-case \uFfFf gives three bytes
    put_byte(ChBackslash);
    put_byte(ChU);
    put_byte("F");
    put_byte("f");
    put_byte("F");
    put_byte("f");
    put_byte(ChBackslash);
    put_byte(ChU);
    put_byte("0");
    put_byte("g");
    put_byte(ChBackslash);
    feed_q.push_back('{ch: 8'h5A, eod: 1'b1});
    feed_q.push_back('{ch: 8'hA5, eod: 1'b1});
  endtask

  task automatic queue_traffic(input int unsigned n);
    int unsigned start;
    int unsigned pick;
    int unsigned good;
    logic [7:0]  c;
    logic [4:0]  nib;
    logic [15:0] cp;
    start = feed_q.size();
    while (feed_q.size() - start < n) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        do c = 8'($urandom_range(8'hFF, 8'h20));
        while (c == ChBackslash || c == ChQuote);
        put_byte(c);
      end else if (pick < 50) begin
        put_byte(ChBackslash);
        put_byte(escape_char(esc_rr));
        esc_rr++;
      end else if (pick < 72) begin
        cp = pick_code_point();
        put_byte(ChBackslash);
        put_byte(ChU);
        for (int i = 3; i >= 0; i--) put_byte(hex_char(cp[i*4 +: 4], 1'($urandom_range(1))));
      end else if (pick < 80) begin
        put_byte(ChQuote);
      end else if (pick < 88) begin
        put_byte(8'($urandom_range(8'hFF)));
      end else if (pick < 93) begin
        put_byte(ChBackslash);
        put_byte(8'($urandom_range(8'hFF)));
      end else if (pick < 97) begin
        // \u cut short by a non-hex byte
        good = $urandom_range(3);
        put_byte(ChBackslash);
        put_byte(ChU);
        repeat (good) put_byte(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
        do begin
          c   = 8'($urandom_range(8'hFF));
          nib = hex_nibble(c);
        end while (!nib[4]);
        put_byte(c);
      end else begin
        feed_q.push_back('{ch: 8'($urandom_range(8'hFF)), eod: 1'b1});
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (feed_q.size() != 0 || in_ch.valid || decoded_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one transfer per handshake, random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid       <= 1'b0;
      in_ch.in_byte     <= 8'h00;
      in_ch.end_of_data <= 1'b0;
      esc_state = ST_TEXT;
      code_acc  = '0;
    end else begin
      drv_busy = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        unescape_step(in_ch.in_byte, in_ch.end_of_data);
        bytes_taken++;
        drv_busy = 1'b0;
      end
      if (!drv_busy && feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item = feed_q.pop_front();
        in_ch.in_byte     <= drv_item.ch;
        in_ch.end_of_data <= drv_item.eod;
        drv_busy = 1'b1;
      end
      in_ch.valid <= drv_busy;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result transfer, random stalls, long hold-off on request
  // ---------------------------------------------------------------------------
  task automatic check_result();
    decoded_t want;
    if (decoded_q.size() == 0) begin
      mismatches++;
      $display("%0t: expected no result, got byte %02h kind %0d err %0d last %0b", $time,
               out_ch.out_byte, out_ch.kind, out_ch.error_code, out_ch.last);
      return;
    end
    want = decoded_q.pop_front();
    results_seen++;
    if (out_ch.out_byte !== want.data || out_ch.kind !== want.kind ||
        out_ch.error_code !== want.err || out_ch.last !== want.last) begin
      mismatches++;
      $display("%0t: expected %02h/%0d/%0d/%0b, got %02h/%0d/%0d/%0b (byte/kind/err/last)",
               $time, want.data, want.kind, want.err, want.last,
               out_ch.out_byte, out_ch.kind, out_ch.error_code, out_ch.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_result();
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still pending", cycle_cnt,
               decoded_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence of phases
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no idling on either side; stall the output long enough to back up the input
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_directed();
    queue_traffic(10);
    hold_len = 60;
    hold_seq++;
    wait_idle();

    send_idle_pct  = 48;
    recv_stall_pct = 0;
    queue_traffic(30);
    wait_idle();

    send_idle_pct  = 0;
    recv_stall_pct = 48;
    queue_traffic(30);
    wait_idle();

    send_idle_pct  = 38;
    recv_stall_pct = 38;
    queue_traffic(30);
    wait_idle();

    repeat (DrainCycles) @(posedge clk_i);
    $display("Fed %0d raw bytes (directed, escapes, \\u code points, noise, end of data)",
             bytes_taken);
    $display("Checked %0d results over four pacing phases and one long output stall",
             results_seen);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
